// ----- rtl/core/dss_pkg.sv -----
// Shared types, codes and defaults for the dual stack block.
package dss_pkg;

   localparam int STACK_DEPTH_DEFAULT = 16;
   localparam int WORD_WIDTH_DEFAULT  = 32;

   localparam int CMD_W   = 2;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 5;
   localparam int STAT_W  = 2;

   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LIST = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SIZE = 2'd3;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic STACK_BLUE = 1'b0;
   localparam logic STACK_RED  = 1'b1;

   // chain operations
   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_PUSH   = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;
   localparam logic [1:0] OP_ROTATE = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic              stack_select;
      logic [DATA_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [DATA_W-1:0]  data_out;
      logic [COUNT_W-1:0] count;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] op;
   } chain_ctl_type;

endpackage

// ----- rtl/core/dual_stack_shared_store.sv -----
// Push, pop and size put their result word in the output register in the cycle after the
// request word: one request word per cycle while the output is not stalled and no list
// runs, one result word each. A list enters the list state, then puts each word in that
// register whenever it is free; n entries give n words, request side held until the last,
// one chain rotation per word. An empty list gives a single result word with empty status.
// Synchronous reset clears both counts and all cell valid bits; words are not reset.
module dual_stack_shared_store
   import dss_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
   parameter int WORD_WIDTH  = WORD_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LIST = 1'b1;

   logic                  state_ff, state_in;
   logic                  list_sel_ff, list_sel_in;
   logic [CNT_W-1:0]      list_left_ff, list_left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   chain_ctl_type         ctl_blue, ctl_red;
   logic [WORD_WIDTH-1:0] top_blue, top_red, top_sel;
   logic [CNT_W-1:0]      cnt_blue, cnt_red, cnt_sel;
   logic [1:0]            op_sel;
   logic                  sel, out_free, accept;
   logic [WORD_WIDTH-1:0] push_word;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == ST_LIST) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign sel       = (state_ff == ST_LIST) ? list_sel_ff : req_data.stack_select;
   assign top_sel   = (sel == STACK_RED) ? top_red : top_blue;
   assign cnt_sel   = (sel == STACK_RED) ? cnt_red : cnt_blue;
   assign push_word = WORD_WIDTH'(req_data.push_value);

   always_comb begin
      state_in     = state_ff;
      list_sel_in  = list_sel_ff;
      list_left_in = list_left_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      op_sel       = OP_HOLD;
      if (accept) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.status   = STATUS_OK;
         rsp_data_in.data_out = '0;
         rsp_data_in.count    = COUNT_W'(cnt_sel);
         rsp_data_in.last     = 1'b1;
         case (req_data.command)
            CMD_PUSH: begin
               if (cnt_sel == CNT_W'(STACK_DEPTH)) begin
                  rsp_data_in.status = STATUS_FULL;
               end else begin
                  rsp_data_in.count = COUNT_W'(CNT_W'(cnt_sel + 1'b1));
                  op_sel            = OP_PUSH;
               end
            end
            CMD_POP: begin
               if (cnt_sel == '0) begin
                  rsp_data_in.status = STATUS_EMPTY;
               end else begin
                  rsp_data_in.data_out = DATA_W'(top_sel);
                  rsp_data_in.count    = COUNT_W'(CNT_W'(cnt_sel - 1'b1));
                  op_sel               = OP_POP;
               end
            end
            CMD_LIST: begin
               if (cnt_sel == '0) begin
                  rsp_data_in.status = STATUS_EMPTY;
               end else begin
                  rsp_valid_in = rsp_valid_ff && rsp_stall;
                  rsp_data_in  = rsp_data_ff;
                  state_in     = ST_LIST;
                  list_sel_in  = req_data.stack_select;
                  list_left_in = cnt_sel;
               end
            end
            CMD_SIZE: begin
               if (cnt_sel == '0) begin
                  rsp_data_in.status = STATUS_EMPTY;
               end
            end
            default: begin
               rsp_data_in.status = STATUS_OK;
            end
         endcase
      end else if (state_ff == ST_LIST && out_free) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.status   = STATUS_OK;
         rsp_data_in.data_out = DATA_W'(top_sel);
         rsp_data_in.count    = COUNT_W'(cnt_sel);
         rsp_data_in.last     = (list_left_ff == CNT_W'(1));
         op_sel               = OP_ROTATE;
         list_left_in         = CNT_W'(list_left_ff - 1'b1);
         if (list_left_ff == CNT_W'(1)) begin
            state_in = ST_IDLE;
         end
      end
   end

   assign ctl_blue.op = (sel == STACK_BLUE) ? op_sel : OP_HOLD;
   assign ctl_red.op  = (sel == STACK_RED)  ? op_sel : OP_HOLD;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         list_left_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         list_left_ff <= list_left_in;
      end
   end

   always_ff @(posedge clock) begin
      list_sel_ff <= list_sel_in;
      rsp_data_ff <= rsp_data_in;
   end

   dss_chain #(
      .STACK_DEPTH(STACK_DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_blue (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_blue),
      .push_data(push_word),
      .top_data (top_blue),
      .count    (cnt_blue)
   );

   dss_chain #(
      .STACK_DEPTH(STACK_DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_red (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_red),
      .push_data(push_word),
      .top_data (top_red),
      .count    (cnt_red)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/core/dss_cell.sv -----
// One stack cell: holds a word and its valid bit, shifts with its neighbors.
module dss_cell
   import dss_pkg::*;
#(
   parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  chain_ctl_type         ctl,
   input  logic [WORD_WIDTH-1:0] data_above,
   input  logic                  valid_above,
   input  logic [WORD_WIDTH-1:0] data_below,
   input  logic                  valid_below,
   input  logic [WORD_WIDTH-1:0] wrap_data,
   output logic [WORD_WIDTH-1:0] data,
   output logic                  valid
);

   logic [WORD_WIDTH-1:0] data_ff, data_in;
   logic                  valid_ff, valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      case (ctl.op)
         OP_PUSH: begin
            data_in  = data_above;
            valid_in = valid_above;
         end
         OP_POP: begin
            data_in  = data_below;
            valid_in = valid_below;
         end
         OP_ROTATE: begin
            // bottom occupied cell takes the old top word
            data_in = (valid_ff && !valid_below) ? wrap_data : data_below;
         end
         default: begin
            data_in  = data_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign valid = valid_ff;

endmodule

// ----- rtl/core/dss_chain.sv -----
// One stack: a row of cells with the top at cell 0, plus its entry count.
module dss_chain
   import dss_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
   parameter int WORD_WIDTH  = WORD_WIDTH_DEFAULT,
   localparam int CNT_W      = $clog2(STACK_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  chain_ctl_type         ctl,
   input  logic [WORD_WIDTH-1:0] push_data,
   output logic [WORD_WIDTH-1:0] top_data,
   output logic [CNT_W-1:0]      count
);

   logic [WORD_WIDTH-1:0] cell_data  [STACK_DEPTH];
   logic                  cell_valid [STACK_DEPTH];
   logic [CNT_W-1:0]      count_ff, count_in;

   genvar i;
   generate
      for (i = 0; i < STACK_DEPTH; i++) begin : g_cell
         logic [WORD_WIDTH-1:0] above_d, below_d;
         logic                  above_v, below_v;
         if (i == 0) begin : g_top
            assign above_d = push_data;
            assign above_v = 1'b1;
         end else begin : g_mid
            assign above_d = cell_data[i-1];
            assign above_v = cell_valid[i-1];
         end
         if (i == STACK_DEPTH - 1) begin : g_bot
            assign below_d = '0;
            assign below_v = 1'b0;
         end else begin : g_up
            assign below_d = cell_data[i+1];
            assign below_v = cell_valid[i+1];
         end
         dss_cell #(
            .WORD_WIDTH(WORD_WIDTH)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .data_above (above_d),
            .valid_above(above_v),
            .data_below (below_d),
            .valid_below(below_v),
            .wrap_data  (cell_data[0]),
            .data       (cell_data[i]),
            .valid      (cell_valid[i])
         );
      end
   endgenerate

   always_comb begin
      case (ctl.op)
         OP_PUSH: count_in = CNT_W'(count_ff + 1'b1);
         OP_POP:  count_in = CNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign top_data = cell_data[0];
   assign count    = count_ff;

endmodule

// ----- rtl/core/dss_checker.sv -----
// Port-level checks for the dual stack block, bound to the top level.
module dss_checker
   import dss_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request word changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_EMPTY |->
         rsp_data.count == '0 && rsp_data.data_out == '0 && rsp_data.last)
      else $error("empty result carries data or count");

   a_full_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_FULL |->
         rsp_data.data_out == '0 && rsp_data.last)
      else $error("full result malformed");

   a_list_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> req_stall)
      else $error("request taken in the middle of a list");

endmodule

bind dual_stack_shared_store dss_checker u_dss_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

// ----- bench/dual_stack_shared_store_check.sv -----
// Checker for the dual stack block: predicts every result word and compares it.
`timescale 1ns / 100ps
module dual_stack_shared_store_check
   import dss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      failures,
   output int      pending
);

   localparam int DEPTH = STACK_DEPTH_DEFAULT;
   localparam int IDX_W = $clog2(2 * DEPTH);

   logic [DATA_W-1:0] word_store [2*DEPTH];
   int                blue_fill;
   int                red_fill;
   rsp_type           stack_replies [$];

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      failures++;
   endtask

   function automatic void apply_stack_command(input req_type w);
      int      n;
      int      base;
      rsp_type r;
      n    = (w.stack_select == STACK_RED) ? red_fill : blue_fill;
      base = (w.stack_select == STACK_RED) ? DEPTH : 0;
      r    = '0;
      r.last = 1'b1;
      case (w.command)
         CMD_PUSH: begin
            if (n >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               word_store[IDX_W'(base + n)] = w.push_value;
               n++;
               r.status = STATUS_OK;
            end
            r.count = COUNT_W'(n);
            stack_replies.push_back(r);
         end
         CMD_POP: begin
            if (n == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               n--;
               r.status   = STATUS_OK;
               r.data_out = word_store[IDX_W'(base + n)];
               r.count    = COUNT_W'(n);
            end
            stack_replies.push_back(r);
         end
         CMD_LIST: begin
            if (n == 0) begin
               r.status = STATUS_EMPTY;
               stack_replies.push_back(r);
            end else begin
               for (int i = 0; i < n; i++) begin
                  r.status   = STATUS_OK;
                  r.data_out = word_store[IDX_W'(base + n - 1 - i)];
                  r.count    = COUNT_W'(n);
                  r.last     = (i == n - 1);
                  stack_replies.push_back(r);
               end
            end
         end
         CMD_SIZE: begin
            r.status = (n == 0) ? STATUS_EMPTY : STATUS_OK;
            r.count  = COUNT_W'(n);
            stack_replies.push_back(r);
         end
         default: begin
            r.status = STATUS_OK;
         end
      endcase
      if (w.stack_select == STACK_RED) red_fill = n;
      else blue_fill = n;
   endfunction

   task automatic compare_reply(input rsp_type got);
      rsp_type want;
      if (stack_replies.size() == 0) begin
         report_mismatch("unexpected result word", got.data_out, '0);
         return;
      end
      want = stack_replies.pop_front();
      if (got.status != want.status)
         report_mismatch("status", DATA_W'(got.status), DATA_W'(want.status));
      if (got.data_out != want.data_out)
         report_mismatch("data_out", got.data_out, want.data_out);
      if (got.count != want.count)
         report_mismatch("count", DATA_W'(got.count), DATA_W'(want.count));
      if (got.last != want.last)
         report_mismatch("last", DATA_W'(got.last), DATA_W'(want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         blue_fill = 0;
         red_fill  = 0;
         stack_replies.delete();
      end else begin
         if (req_valid && !req_stall) apply_stack_command(req_data);
         if (rsp_valid && !rsp_stall) compare_reply(rsp_data);
      end
      pending = stack_replies.size();
   end

endmodule

// ----- bench/dual_stack_shared_store_test.sv -----
// Top of the dual stack testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module dual_stack_shared_store_test;
   import dss_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      failures;
   int      pending;
   int      idle_pct  = 0;
   int      stall_pct = 0;

   dual_stack_shared_store dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   dual_stack_shared_store_check stack_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic sel,
                            input logic [DATA_W-1:0] value);
      req_type w;
      w.command      = cmd;
      w.stack_select = sel;
      w.push_value   = value;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // long runs of mostly pushes or mostly pops so both stacks hit full and empty
   task automatic run_phase(input int items, input int idle, input int stall);
      logic             filling;
      int               pick;
      logic [CMD_W-1:0] cmd;
      idle_pct = idle;
      stall_pct <= stall;
      filling = 1'($urandom_range(1));
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(39) == 0) filling = !filling;
         pick = $urandom_range(99);
         if (pick < (filling ? 70 : 10)) cmd = CMD_PUSH;
         else if (pick < 80) cmd = CMD_POP;
         else if (pick < 90) cmd = CMD_LIST;
         else cmd = CMD_SIZE;
         send_word(cmd, 1'($urandom_range(1)), $urandom());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_word(CMD_POP, STACK_BLUE, '0);
      send_word(CMD_POP, STACK_RED, '1);
      send_word(CMD_SIZE, STACK_RED, '0);
      send_word(CMD_LIST, STACK_RED, '0);
      send_word(CMD_PUSH, STACK_BLUE, 32'h0000_0000);
      send_word(CMD_PUSH, STACK_BLUE, 32'hFFFF_FFFF);
      send_word(CMD_LIST, STACK_BLUE, '0);
      send_word(CMD_POP, STACK_BLUE, '0);
      send_word(CMD_POP, STACK_BLUE, '0);
      for (int i = 0; i < STACK_DEPTH_DEFAULT; i++)
         send_word(CMD_PUSH, STACK_RED, i[0] ? 32'h5555_5555 : 32'hAAAA_AAAA);
      send_word(CMD_PUSH, STACK_RED, $urandom());
      send_word(CMD_LIST, STACK_RED, '0);

      run_phase(105, 0, 0);
      run_phase(105, 74, 0);
      run_phase(105, 0, 74);
      run_phase(105, 18, 18);

      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (failures == 0) begin
         $display("dual_stack_shared_store regression: pass");
      end else begin
         $display("dual_stack_shared_store regression: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("dual_stack_shared_store regression: fail");
      $finish;
   end

endmodule
